// ===== design/i2c_master_transfer_sequencer_defines.svh =====
// Assertion macros shared by the I2C master transfer sequencer RTL.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define I2CMTS_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("i2cmts: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define I2CMTS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("i2cmts: next-cycle check failed");

`endif

// ===== design/i2cmts_pkg.sv =====
// Package: types, codes and widths of the I2C master transfer sequencer.
package i2cmts_pkg;

    localparam int LEN_W        = 16;
    localparam int LEN_BITS_DEF = 16;
    localparam int ADDR_W       = 7;
    localparam int BYTE_W       = 8;
    localparam int FLAG_W       = 6;
    localparam int NOTE_W       = 5;
    localparam logic ACK_RESET  = 1'b1;

    // Transaction kinds on the input channel
    typedef enum logic [1:0] {
        KIND_TX_START = 2'd0,
        KIND_RX_START = 2'd1,
        KIND_EVENT    = 2'd2
    } kind_t;

    // Transfer state
    typedef enum logic [1:0] {
        ST_READY = 2'd0,
        ST_TX    = 2'd1,
        ST_RX    = 2'd2
    } xfer_state_t;

    // Event flag bit positions
    localparam int FL_SB    = 0;
    localparam int FL_ADDR  = 1;
    localparam int FL_BTF   = 2;
    localparam int FL_STOPF = 3;
    localparam int FL_TXE   = 4;
    localparam int FL_RXNE  = 5;

    // Notification bit positions
    localparam int NT_TX_DONE = 0;
    localparam int NT_RX_DONE = 1;
    localparam int NT_STOP    = 2;
    localparam int NT_DATA_RQ = 3;
    localparam int NT_DATA_RX = 4;

    // Fixed-width control state
    typedef struct packed {
        xfer_state_t        xfer_state;
        logic [ADDR_W-1:0]  target_addr;
        logic               hold_bus;
        logic               irq_on;
        logic               ack_now;
    } ctl_t;

    // One result transaction
    typedef struct packed {
        logic [1:0]         prior_state;
        logic               gen_start;
        logic               dr_write;
        logic [BYTE_W-1:0]  dr_value;
        logic               tx_taken;
        logic               rx_valid;
        logic [BYTE_W-1:0]  rx_value;
        logic               clear_addr;
        logic               ack_bit;
        logic               gen_stop;
        logic [NOTE_W-1:0]  notify;
        logic               irq_enabled;
    } res_t;

endpackage

// ===== design/i2c_master_transfer_sequencer.sv =====
// Top level of the I2C master transfer sequencer: input stage, state and result stage.
//
// Use: the s_ channel carries start requests (transmit or receive) and
// peripheral event transactions; each accepted transaction yields exactly one
// result transaction on the m_ channel, in order, telling the driver which
// peripheral register actions to take (start, data write, ADDR clear, stop,
// ACK level, interrupt enable) plus notifications.
// cfg_we/cfg_wdata write the ACK level restored when a reception closes;
// write it only while no transaction is in flight.
// Path: a transaction passes through one input register and one result register,
// with combinational step logic between them.
// Throughput: one transaction per cycle while m_ready is high; the transfer state is
// updated in the same cycle the result register loads, so the next one sees it.
// Stall: while m_ready is low the result holds, the input register still
// takes one more transaction, then s_ready drops until the result drains.
// Reset: aresetn low clears both channels and the transfer state to ready,
// interrupts off, ACK level and its configuration register to enabled.
`include "i2c_master_transfer_sequencer_defines.svh"

module i2c_master_transfer_sequencer
    import i2cmts_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [ADDR_W-1:0]  s_slave_addr,
    input  logic [LEN_W-1:0]   s_length,
    input  logic               s_repeated_start,
    input  logic [FLAG_W-1:0]  s_event_flags,
    input  logic               s_master_mode,
    input  logic               s_transmitter,
    input  logic [BYTE_W-1:0]  s_rx_byte,
    input  logic [BYTE_W-1:0]  s_tx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_prior_state,
    output logic               m_gen_start,
    output logic               m_dr_write,
    output logic [BYTE_W-1:0]  m_dr_value,
    output logic               m_tx_taken,
    output logic               m_rx_valid,
    output logic [BYTE_W-1:0]  m_rx_value,
    output logic               m_clear_addr,
    output logic               m_ack_bit,
    output logic               m_gen_stop,
    output logic [NOTE_W-1:0]  m_notify,
    output logic               m_irq_enabled
);

    localparam ctl_t CTL_RESET = '{
        xfer_state:  ST_READY,
        target_addr: '0,
        hold_bus:    1'b0,
        irq_on:      1'b0,
        ack_now:     ACK_RESET
    };

    logic [LEN_BITS-1:0] len_in;

    logic                in_valid_reg,  in_valid_next;
    logic [1:0]          kind_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [LEN_BITS-1:0] len_reg;
    logic                rs_reg;
    logic [FLAG_W-1:0]   flags_reg;
    logic                msl_reg;
    logic                tra_reg;
    logic [BYTE_W-1:0]   rxb_reg;
    logic [BYTE_W-1:0]   txb_reg;

    logic                ack_enable_reg;
    ctl_t                ctl_reg,        ctl_next;
    logic [LEN_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [LEN_BITS-1:0] rx_total_reg,   rx_total_next;

    logic                out_valid_reg,  out_valid_next;
    res_t                res_reg,        res_next;

    logic                in_fire;
    logic                advance;
    logic                step_fire;

    // Fit the length field to the counter width
    if (LEN_BITS > LEN_W) begin : g_len_wide
        assign len_in = {{(LEN_BITS - LEN_W){1'b0}}, s_length};
    end else begin : g_len_narrow
        assign len_in = s_length[LEN_BITS-1:0];
    end

    // Handshake: the result stage advances when empty or drained
    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || advance;
    assign in_fire   = s_valid && s_ready;
    assign step_fire = in_valid_reg && advance;

    always_comb begin
        in_valid_next  = in_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    // Hold the accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (in_fire) begin
            kind_reg  <= s_kind;
            addr_reg  <= s_slave_addr;
            len_reg   <= len_in;
            rs_reg    <= s_repeated_start;
            flags_reg <= s_event_flags;
            msl_reg   <= s_master_mode;
            tra_reg   <= s_transmitter;
            rxb_reg   <= s_rx_byte;
            txb_reg   <= s_tx_byte;
        end
    end

    i2cmts_step #(
        .LEN_BITS (LEN_BITS)
    ) u_step (
        .kind           (kind_reg),
        .slave_addr     (addr_reg),
        .length         (len_reg),
        .repeated_start (rs_reg),
        .event_flags    (flags_reg),
        .master_mode    (msl_reg),
        .transmitter    (tra_reg),
        .rx_byte        (rxb_reg),
        .tx_byte        (txb_reg),
        .ack_enable     (ack_enable_reg),
        .ctl_cur        (ctl_reg),
        .bytes_left_cur (bytes_left_reg),
        .rx_total_cur   (rx_total_reg),
        .ctl_nxt        (ctl_next),
        .bytes_left_nxt (bytes_left_next),
        .rx_total_nxt   (rx_total_next),
        .res            (res_next)
    );

    // Advance transfer state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_enable_reg <= ACK_RESET;
            ctl_reg        <= CTL_RESET;
            bytes_left_reg <= '0;
            rx_total_reg   <= '0;
        end else begin
            if (cfg_we) begin
                ack_enable_reg <= cfg_wdata;
            end
            if (step_fire) begin
                ctl_reg        <= ctl_next;
                bytes_left_reg <= bytes_left_next;
                rx_total_reg   <= rx_total_next;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (step_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_prior_state = res_reg.prior_state;
    assign m_gen_start   = res_reg.gen_start;
    assign m_dr_write    = res_reg.dr_write;
    assign m_dr_value    = res_reg.dr_value;
    assign m_tx_taken    = res_reg.tx_taken;
    assign m_rx_valid    = res_reg.rx_valid;
    assign m_rx_value    = res_reg.rx_value;
    assign m_clear_addr  = res_reg.clear_addr;
    assign m_ack_bit     = res_reg.ack_bit;
    assign m_gen_stop    = res_reg.gen_stop;
    assign m_notify      = res_reg.notify;
    assign m_irq_enabled = res_reg.irq_enabled;

    // Interrupts are on exactly while a transfer is open
    `I2CMTS_ASSERT_IMPLY(a_irq_tracks_busy, aclk, aresetn, 1'b1,
        ctl_reg.irq_on == (ctl_reg.xfer_state != ST_READY))
    // A start is only requested from the ready state
    `I2CMTS_ASSERT_IMPLY(a_start_from_ready, aclk, aresetn, m_valid && m_gen_start,
        m_prior_state == ST_READY)
    // A consumed transmit byte is always written to the data register
    `I2CMTS_ASSERT_IMPLY(a_taken_writes, aclk, aresetn, m_valid && m_tx_taken,
        m_dr_write && m_prior_state == ST_TX)
    // Idle payload fields read as zero
    `I2CMTS_ASSERT_IMPLY(a_idle_payload_zero, aclk, aresetn, m_valid,
        (m_dr_write || m_dr_value == '0) && (m_rx_valid || m_rx_value == '0))
    // The byte counter moves only when a transaction is processed
    `I2CMTS_ASSERT_NEXT(a_count_stable, aclk, aresetn, !step_fire,
        $stable(bytes_left_reg))

endmodule

// ===== design/i2cmts_step.sv =====
// Next-state and result logic for one transaction of the I2C master sequencer.
module i2cmts_step
    import i2cmts_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  logic [1:0]          kind,
    input  logic [ADDR_W-1:0]   slave_addr,
    input  logic [LEN_BITS-1:0] length,
    input  logic                repeated_start,
    input  logic [FLAG_W-1:0]   event_flags,
    input  logic                master_mode,
    input  logic                transmitter,
    input  logic [BYTE_W-1:0]   rx_byte,
    input  logic [BYTE_W-1:0]   tx_byte,
    input  logic                ack_enable,
    input  ctl_t                ctl_cur,
    input  logic [LEN_BITS-1:0] bytes_left_cur,
    input  logic [LEN_BITS-1:0] rx_total_cur,
    output ctl_t                ctl_nxt,
    output logic [LEN_BITS-1:0] bytes_left_nxt,
    output logic [LEN_BITS-1:0] rx_total_nxt,
    output res_t                res
);

    localparam logic [LEN_BITS-1:0] LEN_ZERO = '0;
    localparam logic [LEN_BITS-1:0] LEN_ONE  = LEN_BITS'(1);
    localparam logic [LEN_BITS-1:0] LEN_TWO  = LEN_BITS'(2);

    // Walk the flags in priority order, each seeing the effects of the ones before
    always_comb begin
        ctl_nxt         = ctl_cur;
        bytes_left_nxt  = bytes_left_cur;
        rx_total_nxt    = rx_total_cur;
        res             = '0;
        res.prior_state = ctl_cur.xfer_state;

        case (kind)
            KIND_TX_START, KIND_RX_START: begin
                // Latch a new transfer only when ready
                if (ctl_cur.xfer_state == ST_READY) begin
                    ctl_nxt.xfer_state  = (kind == KIND_TX_START) ? ST_TX : ST_RX;
                    bytes_left_nxt      = length;
                    if (kind == KIND_RX_START) begin
                        rx_total_nxt = length;
                    end
                    ctl_nxt.target_addr = slave_addr;
                    ctl_nxt.hold_bus    = repeated_start;
                    ctl_nxt.irq_on      = 1'b1;
                    res.gen_start       = 1'b1;
                end
            end
            KIND_EVENT: begin
                if (ctl_cur.irq_on) begin
                    // Start sent: write the address byte with direction bit
                    if (event_flags[FL_SB]) begin
                        if (ctl_nxt.xfer_state == ST_TX) begin
                            res.dr_write = 1'b1;
                            res.dr_value = {ctl_nxt.target_addr, 1'b0};
                        end else if (ctl_nxt.xfer_state == ST_RX) begin
                            res.dr_write = 1'b1;
                            res.dr_value = {ctl_nxt.target_addr, 1'b1};
                        end
                    end
                    // Address done: drop ACK for a single-byte read, clear ADDR
                    if (event_flags[FL_ADDR]) begin
                        if (master_mode && ctl_nxt.xfer_state == ST_RX
                                && rx_total_nxt == LEN_ONE) begin
                            ctl_nxt.ack_now = 1'b0;
                        end
                        res.clear_addr = 1'b1;
                    end
                    // Byte finished with nothing left: close the transmit
                    if (event_flags[FL_BTF] && event_flags[FL_TXE]
                            && ctl_nxt.xfer_state == ST_TX && bytes_left_nxt == LEN_ZERO) begin
                        if (!ctl_nxt.hold_bus) begin
                            res.gen_stop = 1'b1;
                        end
                        ctl_nxt.irq_on             = 1'b0;
                        ctl_nxt.xfer_state         = ST_READY;
                        bytes_left_nxt             = LEN_ZERO;
                        res.notify[NT_TX_DONE]     = 1'b1;
                    end
                    if (event_flags[FL_STOPF]) begin
                        res.notify[NT_STOP] = 1'b1;
                    end
                    // Transmit empty: feed the next byte or ask the slave side for data
                    if (event_flags[FL_TXE]) begin
                        if (master_mode) begin
                            if (ctl_nxt.xfer_state == ST_TX && bytes_left_nxt != LEN_ZERO) begin
                                res.dr_write   = 1'b1;
                                res.dr_value   = tx_byte;
                                res.tx_taken   = 1'b1;
                                bytes_left_nxt = bytes_left_nxt - LEN_ONE;
                            end
                        end else if (transmitter) begin
                            res.notify[NT_DATA_RQ] = 1'b1;
                        end
                    end
                    // Receive full: take the byte, drop ACK before the last, close
                    if (event_flags[FL_RXNE]) begin
                        if (master_mode) begin
                            if (ctl_nxt.xfer_state == ST_RX) begin
                                if (bytes_left_nxt == LEN_ONE) begin
                                    res.rx_valid   = 1'b1;
                                    res.rx_value   = rx_byte;
                                    bytes_left_nxt = LEN_ZERO;
                                end else if (bytes_left_nxt > LEN_ONE) begin
                                    if (bytes_left_nxt == LEN_TWO) begin
                                        ctl_nxt.ack_now = 1'b0;
                                    end
                                    res.rx_valid   = 1'b1;
                                    res.rx_value   = rx_byte;
                                    bytes_left_nxt = bytes_left_nxt - LEN_ONE;
                                end
                                if (bytes_left_nxt == LEN_ZERO) begin
                                    if (!ctl_nxt.hold_bus) begin
                                        res.gen_stop = 1'b1;
                                    end
                                    ctl_nxt.irq_on         = 1'b0;
                                    ctl_nxt.xfer_state     = ST_READY;
                                    rx_total_nxt           = LEN_ZERO;
                                    ctl_nxt.ack_now        = ack_enable;
                                    res.notify[NT_RX_DONE] = 1'b1;
                                end
                            end
                        end else if (!transmitter) begin
                            res.notify[NT_DATA_RX] = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        res.ack_bit     = ctl_nxt.ack_now;
        res.irq_enabled = ctl_nxt.irq_on;
    end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the I2C master transfer sequencer.
`timescale 1ns / 1ps

module testbench
    import i2cmts_pkg::*;
();

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          REPORT_LIMIT   = 40;
    localparam int          PHASE_ITEMS    = 170;
    localparam logic [1:0]  KIND_UNUSED    = 2'd3;

    // Event flag masks
    localparam logic [FLAG_W-1:0] EV_SB    = 6'b1 << FL_SB;
    localparam logic [FLAG_W-1:0] EV_ADDR  = 6'b1 << FL_ADDR;
    localparam logic [FLAG_W-1:0] EV_BTF   = 6'b1 << FL_BTF;
    localparam logic [FLAG_W-1:0] EV_STOPF = 6'b1 << FL_STOPF;
    localparam logic [FLAG_W-1:0] EV_TXE   = 6'b1 << FL_TXE;
    localparam logic [FLAG_W-1:0] EV_RXNE  = 6'b1 << FL_RXNE;
    localparam logic [FLAG_W-1:0] EV_ALL   = 6'h3F;

    // One input transaction
    typedef struct packed {
        logic [1:0]         kind;
        logic [ADDR_W-1:0]  slave_addr;
        logic [LEN_W-1:0]   length;
        logic               repeated_start;
        logic [FLAG_W-1:0]  event_flags;
        logic               master_mode;
        logic               transmitter;
        logic [BYTE_W-1:0]  rx_byte;
        logic [BYTE_W-1:0]  tx_byte;
    } xfer_item_t;

    // Predicts the register actions of each transaction and checks the results
    class register_action_scoreboard;
        xfer_state_t        state;
        logic [LEN_W-1:0]   bytes_left;
        logic [LEN_W-1:0]   rx_total;
        logic [ADDR_W-1:0]  target;
        logic               hold_bus;
        logic               irq_on;
        logic               ack_now;
        logic               ack_enable;
        res_t               pending_actions[$];
        int                 mismatch_count;

        function new();
            ack_enable     = ACK_RESET;
            state          = ST_READY;
            bytes_left     = '0;
            rx_total       = '0;
            target         = '0;
            hold_bus       = 1'b0;
            irq_on         = 1'b0;
            ack_now        = ACK_RESET;
            mismatch_count = 0;
        endfunction

        function int pending();
            return pending_actions.size();
        endfunction

        // Close the transfer and drop interrupts
        function void close_transfer(ref res_t r);
            if (!hold_bus) r.gen_stop = 1'b1;
            irq_on = 1'b0;
            state  = ST_READY;
        endfunction

        function res_t predict_actions(xfer_item_t it);
            res_t r;
            r = '0;
            r.prior_state = state;
            if (it.kind == KIND_TX_START || it.kind == KIND_RX_START) begin
                // Accept a start request only while ready
                if (state == ST_READY) begin
                    state      = (it.kind == KIND_TX_START) ? ST_TX : ST_RX;
                    bytes_left = it.length;
                    if (it.kind == KIND_RX_START) rx_total = it.length;
                    target      = it.slave_addr;
                    hold_bus    = it.repeated_start;
                    r.gen_start = 1'b1;
                    irq_on      = 1'b1;
                end
            end else if (it.kind == KIND_EVENT && irq_on) begin
                // Send the address byte with the direction bit
                if (it.event_flags[FL_SB]) begin
                    if (state == ST_TX) begin
                        r.dr_write = 1'b1;
                        r.dr_value = {target, 1'b0};
                    end else if (state == ST_RX) begin
                        r.dr_write = 1'b1;
                        r.dr_value = {target, 1'b1};
                    end
                end
                // Clear ADDR, drop ACK first for a single-byte reception
                if (it.event_flags[FL_ADDR]) begin
                    if (it.master_mode && state == ST_RX && rx_total == 1) ack_now = 1'b0;
                    r.clear_addr = 1'b1;
                end
                // Finish a transmission once the last byte is out
                if (it.event_flags[FL_BTF] && state == ST_TX && it.event_flags[FL_TXE]
                        && bytes_left == 0) begin
                    close_transfer(r);
                    bytes_left = '0;
                    r.notify[NT_TX_DONE] = 1'b1;
                end
                if (it.event_flags[FL_STOPF]) r.notify[NT_STOP] = 1'b1;
                // Feed the next transmit byte, or request data in slave transmit mode
                if (it.event_flags[FL_TXE]) begin
                    if (it.master_mode) begin
                        if (state == ST_TX && bytes_left > 0) begin
                            r.dr_write = 1'b1;
                            r.dr_value = it.tx_byte;
                            r.tx_taken = 1'b1;
                            bytes_left = bytes_left - 1'b1;
                        end
                    end else if (it.transmitter) begin
                        r.notify[NT_DATA_RQ] = 1'b1;
                    end
                end
                // Take a received byte, drop ACK before the last one, close at the end
                if (it.event_flags[FL_RXNE]) begin
                    if (it.master_mode) begin
                        if (state == ST_RX) begin
                            if (bytes_left == 1) begin
                                r.rx_valid = 1'b1;
                                r.rx_value = it.rx_byte;
                                bytes_left = '0;
                            end else if (bytes_left > 1) begin
                                if (bytes_left == 2) ack_now = 1'b0;
                                r.rx_valid = 1'b1;
                                r.rx_value = it.rx_byte;
                                bytes_left = bytes_left - 1'b1;
                            end
                            if (bytes_left == 0) begin
                                close_transfer(r);
                                rx_total = '0;
                                ack_now  = ack_enable;
                                r.notify[NT_RX_DONE] = 1'b1;
                            end
                        end
                    end else if (!it.transmitter) begin
                        r.notify[NT_DATA_RX] = 1'b1;
                    end
                end
            end
            r.ack_bit     = ack_now;
            r.irq_enabled = irq_on;
            return r;
        endfunction

        function void note_transaction(xfer_item_t it);
            pending_actions.push_back(predict_actions(it));
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_transaction(res_t got);
            res_t want;
            if (pending_actions.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: result expected none, actual %0h", $time, got);
                return;
            end
            want = pending_actions.pop_front();
            compare_field("prior_state", 8'(want.prior_state), 8'(got.prior_state));
            compare_field("gen_start", 8'(want.gen_start), 8'(got.gen_start));
            compare_field("dr_write", 8'(want.dr_write), 8'(got.dr_write));
            compare_field("dr_value", want.dr_value, got.dr_value);
            compare_field("tx_taken", 8'(want.tx_taken), 8'(got.tx_taken));
            compare_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
            compare_field("rx_value", want.rx_value, got.rx_value);
            compare_field("clear_addr", 8'(want.clear_addr), 8'(got.clear_addr));
            compare_field("ack_bit", 8'(want.ack_bit), 8'(got.ack_bit));
            compare_field("gen_stop", 8'(want.gen_stop), 8'(got.gen_stop));
            compare_field("notify", 8'(want.notify), 8'(got.notify));
            compare_field("irq_enabled", 8'(want.irq_enabled), 8'(got.irq_enabled));
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_we;
    logic               cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_kind;
    logic [ADDR_W-1:0]  s_slave_addr;
    logic [LEN_W-1:0]   s_length;
    logic               s_repeated_start;
    logic [FLAG_W-1:0]  s_event_flags;
    logic               s_master_mode;
    logic               s_transmitter;
    logic [BYTE_W-1:0]  s_rx_byte;
    logic [BYTE_W-1:0]  s_tx_byte;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_prior_state;
    logic               m_gen_start;
    logic               m_dr_write;
    logic [BYTE_W-1:0]  m_dr_value;
    logic               m_tx_taken;
    logic               m_rx_valid;
    logic [BYTE_W-1:0]  m_rx_value;
    logic               m_clear_addr;
    logic               m_ack_bit;
    logic               m_gen_stop;
    logic [NOTE_W-1:0]  m_notify;
    logic               m_irq_enabled;

    register_action_scoreboard board = new();
    int                        items_sent = 0;
    bit                        steady = 1'b0;

    i2c_master_transfer_sequencer uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_slave_addr     (s_slave_addr),
        .s_length         (s_length),
        .s_repeated_start (s_repeated_start),
        .s_event_flags    (s_event_flags),
        .s_master_mode    (s_master_mode),
        .s_transmitter    (s_transmitter),
        .s_rx_byte        (s_rx_byte),
        .s_tx_byte        (s_tx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_prior_state    (m_prior_state),
        .m_gen_start      (m_gen_start),
        .m_dr_write       (m_dr_write),
        .m_dr_value       (m_dr_value),
        .m_tx_taken       (m_tx_taken),
        .m_rx_valid       (m_rx_valid),
        .m_rx_value       (m_rx_value),
        .m_clear_addr     (m_clear_addr),
        .m_ack_bit        (m_ack_bit),
        .m_gen_stop       (m_gen_stop),
        .m_notify         (m_notify),
        .m_irq_enabled    (m_irq_enabled)
    );

    always #10 aclk = ~aclk;

    // Idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Random filler for every field but the kind, which is an event
    function automatic xfer_item_t blank_item();
        xfer_item_t it;
        it.kind           = KIND_EVENT;
        it.slave_addr     = ADDR_W'($urandom);
        it.length         = LEN_W'($urandom);
        it.repeated_start = 1'($urandom);
        it.event_flags    = FLAG_W'($urandom);
        it.master_mode    = 1'($urandom);
        it.transmitter    = 1'($urandom);
        it.rx_byte        = BYTE_W'($urandom);
        it.tx_byte        = BYTE_W'($urandom);
        return it;
    endfunction

    // Present one transaction, hold it until accepted
    task automatic drive_item(xfer_item_t it);
        int gap;
        bit taken;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_kind           <= it.kind;
        s_slave_addr     <= it.slave_addr;
        s_length         <= it.length;
        s_repeated_start <= it.repeated_start;
        s_event_flags    <= it.event_flags;
        s_master_mode    <= it.master_mode;
        s_transmitter    <= it.transmitter;
        s_rx_byte        <= it.rx_byte;
        s_tx_byte        <= it.tx_byte;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end
        board.note_transaction(it);
        items_sent++;
    endtask

    task automatic send_start(logic [1:0] kind, logic [ADDR_W-1:0] addr,
                              logic [LEN_W-1:0] len, logic rs);
        xfer_item_t it;
        it                = blank_item();
        it.kind           = kind;
        it.slave_addr     = addr;
        it.length         = len;
        it.repeated_start = rs;
        drive_item(it);
    endtask

    task automatic send_event(logic [FLAG_W-1:0] flags, logic master, logic tra,
                              logic [BYTE_W-1:0] rxb, logic [BYTE_W-1:0] txb);
        xfer_item_t it;
        it             = blank_item();
        it.event_flags = flags;
        it.master_mode = master;
        it.transmitter = tra;
        it.rx_byte     = rxb;
        it.tx_byte     = txb;
        drive_item(it);
    endtask

    // Any kind with any content; a start that would be taken gets a short length
    task automatic send_noise();
        xfer_item_t it;
        it      = blank_item();
        it.kind = 2'($urandom_range(0, 3));
        if ((it.kind == KIND_TX_START || it.kind == KIND_RX_START) && board.state == ST_READY)
            it.length = LEN_W'($urandom_range(0, 8));
        drive_item(it);
    endtask

    // Walk the open transfer to its end with proper byte events
    task automatic finish_transfer();
        logic [FLAG_W-1:0] flags;
        while (board.state != ST_READY) begin
            if ($urandom_range(0, 19) == 0) begin
                send_noise();
            end else begin
                if (board.state == ST_TX)
                    flags = (board.bytes_left == 0) ? (EV_BTF | EV_TXE) : EV_TXE;
                else
                    flags = EV_RXNE;
                if ($urandom_range(0, 9) == 0) flags |= EV_STOPF;
                if ($urandom_range(0, 9) == 0) flags |= EV_BTF;
                send_event(flags, 1'b1, board.state == ST_TX,
                           BYTE_W'($urandom), BYTE_W'($urandom));
            end
        end
    endtask

    // Start, address phase, then the data bytes
    task automatic run_transfer();
        bit                is_rx;
        int                roll;
        logic [LEN_W-1:0]  len;
        is_rx = 1'($urandom_range(0, 1));
        roll  = $urandom_range(0, 99);
        if (roll < 70)      len = LEN_W'($urandom_range(0, 4));
        else if (roll < 95) len = LEN_W'($urandom_range(5, 20));
        else                len = LEN_W'($urandom_range(21, 80));
        send_start(is_rx ? KIND_RX_START : KIND_TX_START, ADDR_W'($urandom), len,
                   1'($urandom));
        if ($urandom_range(0, 3) == 0) begin
            send_event(EV_SB | EV_ADDR, 1'b1, !is_rx, BYTE_W'($urandom), BYTE_W'($urandom));
        end else begin
            send_event(EV_SB, 1'b1, !is_rx, BYTE_W'($urandom), BYTE_W'($urandom));
            send_event(EV_ADDR, 1'b1, !is_rx, BYTE_W'($urandom), BYTE_W'($urandom));
        end
        finish_transfer();
    endtask

    task automatic run_directed();
        xfer_item_t it;
        // Event while idle, then the unused kind
        send_event(EV_ALL, 1'b1, 1'b1, 8'hFF, 8'hFF);
        it      = blank_item();
        it.kind = KIND_UNUSED;
        drive_item(it);
        // One-byte transmit, with requests arriving while busy
        send_start(KIND_TX_START, 7'h7F, 16'd1, 1'b0);
        send_start(KIND_TX_START, 7'h00, 16'hFFFF, 1'b1);
        send_start(KIND_RX_START, 7'h2A, 16'hFFFF, 1'b1);
        send_event(EV_SB | EV_ADDR | EV_STOPF, 1'b1, 1'b1, 8'h00, 8'h00);
        send_event(EV_TXE, 1'b1, 1'b1, 8'h00, 8'hFF);
        send_event(EV_BTF | EV_TXE, 1'b1, 1'b1, 8'h00, 8'h00);
        // Single-byte receive with repeated start
        send_start(KIND_RX_START, 7'h00, 16'd1, 1'b1);
        send_event(EV_SB, 1'b1, 1'b0, 8'h00, 8'h00);
        send_event(EV_ADDR, 1'b1, 1'b0, 8'h00, 8'h00);
        send_event(EV_RXNE, 1'b1, 1'b0, 8'hFF, 8'h00);
        // Zero-length receive closes on the first receive event
        send_start(KIND_RX_START, 7'h55, 16'd0, 1'b0);
        send_event(EV_RXNE, 1'b1, 1'b0, 8'h12, 8'h00);
        // Three-byte receive drops ACK before the last byte
        send_start(KIND_RX_START, 7'h33, 16'd3, 1'b0);
        send_event(EV_SB | EV_ADDR, 1'b1, 1'b0, 8'h00, 8'h00);
        send_event(EV_RXNE, 1'b1, 1'b0, 8'h00, 8'h00);
        send_event(EV_RXNE, 1'b1, 1'b0, 8'hA5, 8'h00);
        send_event(EV_RXNE, 1'b1, 1'b0, 8'h5A, 8'h00);
        // Zero-length transmit with every flag in one event
        send_start(KIND_TX_START, 7'h11, 16'd0, 1'b0);
        send_event(EV_ALL, 1'b1, 1'b1, 8'hFF, 8'hFF);
        // Slave data events during a transfer only notify
        send_start(KIND_TX_START, 7'h22, 16'd2, 1'b0);
        send_event(EV_TXE | EV_RXNE, 1'b0, 1'b1, 8'h3C, 8'hC3);
        send_event(EV_TXE | EV_RXNE, 1'b0, 1'b0, 8'hC3, 8'h3C);
        finish_transfer();
    endtask

    // Hold the sender until every result is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_ack_enable(logic value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        board.ack_enable = value;
    endtask

    // Result side: random stalls, check each accepted transaction
    initial begin : result_sink
        int   stall_left;
        res_t got;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(negedge aclk);
            if (m_valid && m_ready) begin
                got = '{prior_state: m_prior_state, gen_start: m_gen_start,
                        dr_write: m_dr_write, dr_value: m_dr_value,
                        tx_taken: m_tx_taken, rx_valid: m_rx_valid,
                        rx_value: m_rx_value, clear_addr: m_clear_addr,
                        ack_bit: m_ack_bit, gen_stop: m_gen_stop,
                        notify: m_notify, irq_enabled: m_irq_enabled};
                board.check_transaction(got);
            end
            @(posedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // End the run when nothing moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(negedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int   phase;
        int   phase_goal;
        logic ack_setting;
        aresetn          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= 1'b0;
        s_valid          <= 1'b0;
        s_kind           <= KIND_EVENT;
        s_slave_addr     <= '0;
        s_length         <= '0;
        s_repeated_start <= 1'b0;
        s_event_flags    <= '0;
        s_master_mode    <= 1'b0;
        s_transmitter    <= 1'b0;
        s_rx_byte        <= '0;
        s_tx_byte        <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part with ACK restore disabled
        write_ack_enable(1'b0);
        run_directed();

        // Random phases, each under its own ACK setting
        for (phase = 0; phase < 6; phase++) begin
            wait_drained();
            steady      = (phase == 3);
            ack_setting = (phase < 4) ? (phase % 2 == 0) : 1'($urandom_range(0, 1));
            write_ack_enable(ack_setting);
            phase_goal = items_sent + PHASE_ITEMS;
            while (items_sent < phase_goal) begin
                if ($urandom_range(0, 99) < 85) run_transfer();
                else send_noise();
            end
            finish_transfer();
        end

        // Drain and let the pipeline settle
        wait_drained();
        repeat (10) @(posedge aclk);
        if (board.pending() != 0)
            $display("%0t: %0d results never arrived", $time, board.pending());
        if (board.mismatch_count == 0 && board.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
